// ===== src/utf8d_pkg.sv =====
// ----------------------------------------------------------------------------
// utf8d_pkg
// Types and constants shared by the lenient UTF-8 decoder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package utf8d_pkg;

  localparam logic [20:0] REPL_CP = 21'h00FFFD;

  // Input beat: one byte of text and the end-of-text flag.
  typedef struct packed {
    logic [7:0] byte_in;
    logic       is_last;
  } in_t;

  // Output beat: one decoded code point.
  typedef struct packed {
    logic [20:0] code_point;
    logic        is_replacement;
    logic        last_out;
  } out_t;

  // Results caused by one input byte. Every result but the final one is a
  // replacement character, so a count and the final result describe them.
  typedef struct packed {
    logic [2:0]  cnt;
    logic [20:0] cp;
    logic        repl;
    logic        last;
  } desc_t;

endpackage

`default_nettype wire

// ===== src/utf8_lenient_decoder_core.sv =====
// ----------------------------------------------------------------------------
// utf8_lenient_decoder_core
// Lenient UTF-8 decoder giving code points, with U+FFFD for malformed bytes.
// ----------------------------------------------------------------------------
// The input channel carries one byte per beat with a flag on the final byte
// of the text; the output channel carries one code point per beat. Both use
// valid/stall: a beat moves on a clock edge with valid high and stall low.
// A byte that completes a character, or an ASCII or invalid byte, gives its
// result in the cycle after it is accepted, and such bytes are taken every
// cycle while the receiver does not stall. Continuation bytes of an
// unfinished sequence give no result. A byte that breaks a sequence, or a
// final byte that truncates one, gives up to four results; the result
// register plays them out one per cycle unless the receiver stalls, which
// holds the current beat. The input is taken only once the last pending
// result of the held item leaves. Synchronous reset empties the result
// register and returns the decoder to no pending sequence.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_lenient_decoder_core (
  input  wire             clk,
  input  wire             rst,
  input  wire             in_valid,
  output logic            in_stall,
  input  utf8d_pkg::in_t  in_data,
  output logic            out_valid,
  input  wire             out_stall,
  output utf8d_pkg::out_t out_data
);

  utf8d_pkg::desc_t desc;
  logic             room;
  logic             accept;

  assign in_stall = !room;
  assign accept   = in_valid && room;

  utf8d_decode u_decode (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .in_data (in_data),
    .desc    (desc)
  );

  utf8d_serializer u_serializer (
    .clk       (clk),
    .rst       (rst),
    .load      (accept && (desc.cnt != 3'd0)),
    .desc      (desc),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== src/utf8d_decode.sv =====
// ----------------------------------------------------------------------------
// utf8d_decode
// Sequence state and per-byte decode into a result descriptor.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8d_decode (
  input  wire              clk,
  input  wire              rst,
  input  wire              accept,
  input  utf8d_pkg::in_t   in_data,
  output utf8d_pkg::desc_t desc
);

  logic [20:0] partial_code, partial_code_next;
  logic [1:0]  bytes_needed, bytes_needed_next;
  logic [1:0]  bytes_held, bytes_held_next;

  always_comb begin
    logic [7:0]  b;
    logic        cont;
    logic [2:0]  flushed;
    logic [20:0] shifted;
    b       = in_data.byte_in;
    cont    = (b[7:6] == 2'b10);
    shifted = {partial_code[14:0], b[5:0]};
    flushed = 3'd0;

    partial_code_next = partial_code;
    bytes_needed_next = bytes_needed;
    bytes_held_next   = bytes_held;
    desc.cnt  = 3'd0;
    desc.cp   = utf8d_pkg::REPL_CP;
    desc.repl = 1'b1;
    desc.last = in_data.is_last;

    if (bytes_needed != 2'd0 && cont) begin
      if (bytes_needed == 2'd1) begin
        desc.cnt          = 3'd1;
        desc.cp           = shifted;
        desc.repl         = 1'b0;
        partial_code_next = '0;
        bytes_needed_next = 2'd0;
        bytes_held_next   = 2'd0;
      end else if (in_data.is_last) begin
        // Truncated at the end: every held byte, this one included, is replaced.
        desc.cnt          = {1'b0, bytes_held + 2'd1};
        partial_code_next = '0;
        bytes_needed_next = 2'd0;
        bytes_held_next   = 2'd0;
      end else begin
        partial_code_next = shifted;
        bytes_needed_next = bytes_needed - 2'd1;
        bytes_held_next   = bytes_held + 2'd1;
      end
    end else begin
      // A broken sequence first gives one replacement per held byte.
      if (bytes_needed != 2'd0) begin
        flushed = {1'b0, bytes_held};
      end
      partial_code_next = '0;
      bytes_needed_next = 2'd0;
      bytes_held_next   = 2'd0;
      desc.cnt          = flushed;
      priority casez (b)
        8'b0???????: begin
          desc.cnt  = flushed + 3'd1;
          desc.cp   = {13'd0, b};
          desc.repl = 1'b0;
        end
        8'b110?????, 8'b1110????, 8'b11110???: begin
          if (in_data.is_last) begin
            desc.cnt = flushed + 3'd1;
          end else begin
            bytes_held_next = 2'd1;
            if (b[5] == 1'b0) begin
              partial_code_next = {16'd0, b[4:0]};
              bytes_needed_next = 2'd1;
            end else if (b[4] == 1'b0) begin
              partial_code_next = {17'd0, b[3:0]};
              bytes_needed_next = 2'd2;
            end else begin
              partial_code_next = {18'd0, b[2:0]};
              bytes_needed_next = 2'd3;
            end
          end
        end
        default: begin
          desc.cnt = flushed + 3'd1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      partial_code <= '0;
      bytes_needed <= 2'd0;
      bytes_held   <= 2'd0;
    end else if (accept) begin
      partial_code <= partial_code_next;
      bytes_needed <= bytes_needed_next;
      bytes_held   <= bytes_held_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/utf8d_serializer.sv =====
// ----------------------------------------------------------------------------
// utf8d_serializer
// Holds one descriptor and plays its results out, one beat per cycle unless the receiver stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8d_serializer (
  input  wire              clk,
  input  wire              rst,
  input  wire              load,
  input  utf8d_pkg::desc_t desc,
  output logic             room,
  output logic             out_valid,
  input  wire              out_stall,
  output utf8d_pkg::out_t  out_data
);

  logic        valid;
  logic [2:0]  rem;
  logic [20:0] cp;
  logic        repl;
  logic        last;
  logic        final_beat;

  assign final_beat = (rem == 3'd1);
  // A new descriptor fits once the final beat of the current one leaves.
  assign room       = !valid || (!out_stall && final_beat);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      rem   <= 3'd0;
    end else if (load) begin
      valid <= 1'b1;
      rem   <= desc.cnt;
    end else if (valid && !out_stall) begin
      valid <= !final_beat;
      rem   <= rem - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cp   <= desc.cp;
      repl <= desc.repl;
      last <= desc.last;
    end
  end

  assign out_valid               = valid;
  assign out_data.code_point     = final_beat ? cp : utf8d_pkg::REPL_CP;
  assign out_data.is_replacement = final_beat ? repl : 1'b1;
  assign out_data.last_out       = final_beat && last;

  a_valid_count: assert property (@(posedge clk) disable iff (rst)
    valid |-> (rem != 3'd0 && rem <= 3'd4))
    else $error("serializer holds a descriptor with a bad count");

  a_load_room: assert property (@(posedge clk) disable iff (rst)
    load |-> room)
    else $error("descriptor loaded over results not yet delivered");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    (valid && out_stall) |=> (valid && $stable(rem)))
    else $error("results advanced while the receiver stalled");

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the lenient UTF-8 decoder. Directed byte sequences cover
// ASCII extremes, well-formed 2/3/4-byte characters, invalid leads, broken
// and truncated sequences and a literal U+FFFD. A random part follows,
// mostly well-formed characters with some noise. Every accepted result is
// checked field by field against a decoder model kept in the bench.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  utf8d_pkg::in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  utf8d_pkg::out_t out_data;

  utf8_lenient_decoder_core uut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // Decoder model state.
  logic [20:0] seq_code = '0;
  logic [1:0]  seq_need = '0;
  logic [1:0]  seq_held = '0;

  utf8d_pkg::out_t cp_expected[$];
  int   err_cnt = 0;
  bit   idle_en = 1'b1;
  int   bytes_sent = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("tb_top: errors");
    $finish;
  end

  // Output side stall bursts.
  int stall_left = 0;
  always @(posedge clk) begin
    logic nxt;
    nxt = 1'b0;
    if (stall_left > 0) begin
      stall_left--;
      nxt = 1'b1;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 14) - 1;
      nxt = 1'b1;
    end
    out_stall <= nxt;
  end

  // Result checker.
  always @(posedge clk) begin
    utf8d_pkg::out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (cp_expected.size() == 0) begin
        $error("unexpected result beat: code_point %h", out_data.code_point);
        err_cnt++;
      end else begin
        want = cp_expected.pop_front();
        if (out_data.code_point !== want.code_point) begin
          $error("code_point: expected %h, actual %h", want.code_point,
                 out_data.code_point);
          err_cnt++;
        end
        if (out_data.is_replacement !== want.is_replacement) begin
          $error("is_replacement: expected %b, actual %b", want.is_replacement,
                 out_data.is_replacement);
          err_cnt++;
        end
        if (out_data.last_out !== want.last_out) begin
          $error("last_out: expected %b, actual %b", want.last_out,
                 out_data.last_out);
          err_cnt++;
        end
      end
    end
  end

  // Computes the code points caused by one accepted byte.
  task automatic decode_byte(input utf8d_pkg::in_t beat);
    utf8d_pkg::out_t res[4];
    int   n;
    logic [7:0] b;
    logic taken;
    n = 0;
    b = beat.byte_in;
    taken = 1'b0;
    if (seq_need != 2'd0) begin
      if (b[7:6] == 2'b10) begin
        seq_code = {seq_code[14:0], b[5:0]};
        seq_held = seq_held + 2'd1;
        seq_need = seq_need - 2'd1;
        if (seq_need == 2'd0) begin
          res[n] = '{code_point: seq_code, is_replacement: 1'b0, last_out: 1'b0};
          n++;
          seq_code = '0;
          seq_held = '0;
        end
        taken = 1'b1;
      end else begin
        for (int k = 0; k < seq_held && k < 3; k++) begin
          res[n] = '{code_point: utf8d_pkg::REPL_CP, is_replacement: 1'b1,
                     last_out: 1'b0};
          n++;
        end
        seq_code = '0;
        seq_need = '0;
        seq_held = '0;
      end
    end
    if (!taken) begin
      if (b[7] == 1'b0) begin
        res[n] = '{code_point: {13'd0, b}, is_replacement: 1'b0, last_out: 1'b0};
        n++;
      end else if (b[7:5] == 3'b110) begin
        seq_code = {16'd0, b[4:0]};
        seq_need = 2'd1;
        seq_held = 2'd1;
      end else if (b[7:4] == 4'b1110) begin
        seq_code = {17'd0, b[3:0]};
        seq_need = 2'd2;
        seq_held = 2'd1;
      end else if (b[7:3] == 5'b11110) begin
        seq_code = {18'd0, b[2:0]};
        seq_need = 2'd3;
        seq_held = 2'd1;
      end else begin
        res[n] = '{code_point: utf8d_pkg::REPL_CP, is_replacement: 1'b1,
                   last_out: 1'b0};
        n++;
      end
    end
    if (beat.is_last) begin
      // A sequence still open at the end of the text is flushed.
      if (seq_need != 2'd0) begin
        for (int k = 0; k < seq_held && k < 3; k++) begin
          res[n] = '{code_point: utf8d_pkg::REPL_CP, is_replacement: 1'b1,
                     last_out: 1'b0};
          n++;
        end
        seq_code = '0;
        seq_need = '0;
        seq_held = '0;
      end
      if (n > 0) res[n-1].last_out = 1'b1;
    end
    for (int k = 0; k < n; k++) cp_expected = {cp_expected, res[k]};
  endtask

  task automatic send_byte(input logic [7:0] b, input logic l);
    utf8d_pkg::in_t beat;
    beat.byte_in = b;
    beat.is_last = l;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    decode_byte(beat);
    bytes_sent++;
  endtask

  task automatic test_ascii_extremes();
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b1);
  endtask

  task automatic test_multibyte();
    send_byte(8'hC2, 1'b0);
    send_byte(8'hA9, 1'b0);
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b0);
    send_byte(8'hAC, 1'b0);
    // Largest value a four-byte sequence can carry.
    send_byte(8'hF7, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b1);
  endtask

  task automatic test_literal_replacement();
    send_byte(8'hEF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBD, 1'b0);
  endtask

  task automatic test_invalid_leads();
    send_byte(8'h80, 1'b0);
    send_byte(8'hF8, 1'b0);
    send_byte(8'hFF, 1'b1);
  endtask

  task automatic test_broken_sequence();
    // Three bytes held, then a fresh lead that is itself broken by ASCII.
    send_byte(8'hF0, 1'b0);
    send_byte(8'h90, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hC3, 1'b0);
    send_byte(8'h41, 1'b0);
  endtask

  task automatic test_truncated_end();
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b1);
    // A lead carried by the final byte itself.
    send_byte(8'hF4, 1'b1);
  endtask

  task automatic test_random();
    int len;
    int sel;
    int cut;
    logic [7:0] lead;
    while (bytes_sent < 100) begin
      if (bytes_sent >= 85) idle_en = 1'b0;
      sel = $urandom_range(0, 9);
      if (sel < 8) begin
        len = $urandom_range(1, 4);
        case (len)
          1: lead = {1'b0, 7'($urandom)};
          2: lead = {3'b110, 5'($urandom)};
          3: lead = {4'b1110, 4'($urandom)};
          default: lead = {5'b11110, 3'($urandom)};
        endcase
        // Occasionally the sequence is cut short, by a stray byte or by the
        // end of the text.
        cut = (sel == 7) ? $urandom_range(0, len - 1) : len;
        send_byte(lead, (len == 1 || cut == 0) && $urandom_range(0, 7) == 0);
        for (int k = 1; k < cut; k++)
          send_byte({2'b10, 6'($urandom)}, k == cut - 1 && $urandom_range(0, 7) == 0);
        if (cut < len && len > 1) send_byte(8'($urandom), 1'($urandom));
      end else begin
        send_byte(8'($urandom), $urandom_range(0, 5) == 0);
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_ascii_extremes();
    test_multibyte();
    test_literal_replacement();
    test_invalid_leads();
    test_broken_sequence();
    test_truncated_end();
    test_random();
    in_valid <= 1'b0;
    while (cp_expected.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (err_cnt == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
